// ===== rtl/exp_approx_float32_table_macros.svh =====
// Assertion macros shared by the exp approximation block.
// Included by the top level; depends on nothing else.
`ifndef EXP_APPROX_FLOAT32_TABLE_MACROS_SVH
`define EXP_APPROX_FLOAT32_TABLE_MACROS_SVH

// Implication in the same cycle, checked outside reset.
`define EAF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante implies cons");

// Implication in the next cycle, checked outside reset.
`define EAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante implies cons next cycle");

`endif

// ===== rtl/eaf32t_pkg.sv =====
// Package for the exp approximation block: register codes, table sizing and
// single-precision compare, multiply and add functions. Depends on nothing.
`default_nettype none

package eaf32t_pkg;

   localparam int TABLE_INDEX_BITS = 10;
   localparam int TABLE_DEPTH      = 1 << TABLE_INDEX_BITS;
   localparam int CSR_INDEX_BITS   = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAGIC_BIAS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_A    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_B    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_X      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_X      = 3'd4;

   localparam logic [31:0] MAGIC_BIAS_RESET = 32'h4B40_0000;
   localparam logic [31:0] DEFAULT_NAN      = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT        = 32'h0040_0000;
   localparam logic [31:0] EXP_ADJ          = 32'(127) << TABLE_INDEX_BITS;

   typedef logic [31:0] word_type;

   function automatic logic is_nan(input word_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   // Strict less-than; false when either operand is NaN, and -0 equals +0.
   function automatic logic fp_lt(input word_type a, input word_type b);
      logic r;
      if (is_nan(a) || is_nan(b)) begin
         r = 1'b0;
      end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
         r = 1'b0;
      end else if (a[31] != b[31]) begin
         r = a[31];
      end else if (!a[31]) begin
         r = a[30:0] < b[30:0];
      end else begin
         r = a[30:0] > b[30:0];
      end
      return r;
   endfunction

   // Leading zero count of a 50-bit word.
   function automatic logic [5:0] lzc50(input logic [49:0] m);
      logic [5:0] n;
      logic       hit;
      n   = 6'd50;
      hit = 1'b0;
      for (int i = 49; i >= 0; i--) begin
         if (m[i] && !hit) begin
            n   = 6'(49 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   // Right shift that folds every lost bit into bit zero.
   function automatic logic [49:0] shr_sticky(input logic [49:0] m, input logic [7:0] sh);
      logic [49:0] s;
      logic        lost;
      s    = (sh > 8'd50) ? 50'd0 : (m >> sh);
      lost = (sh > 8'd50) ? (m != 50'd0) : ((s << sh) != m);
      return {s[49:1], s[0] | lost};
   endfunction

   // Round to nearest even and pack. m has its leading one at bit 49 and
   // stands for 1.f * 2^(e-127); results below the normal range go denormal.
   function automatic word_type fp_round(input logic sgn, input logic signed [11:0] e,
                                         input logic [49:0] m);
      logic [49:0] mm;
      logic [7:0]  be;
      logic [7:0]  sh;
      logic [23:0] mant;
      logic        up;
      word_type    w;
      mm = m;
      be = 8'd0;
      sh = 8'd0;
      if (e >= 12'sd255) begin
         w = {sgn, 8'hFF, 23'd0};
      end else begin
         if (e <= 12'sd0) begin
            sh = ((12'sd1 - e) > 12'sd60) ? 8'd60 : 8'(12'sd1 - e);
            mm = shr_sticky(m, sh);
            be = 8'd0;
         end else begin
            be = e[7:0];
         end
         mant = mm[49:26];
         up   = mm[25] & ((|mm[24:0]) | mant[0]);
         w    = {sgn, 31'({be, mant[22:0]}) + 31'(up)};
      end
      return w;
   endfunction

   function automatic word_type fp_mul(input word_type a, input word_type b);
      logic              s;
      logic [23:0]       ma;
      logic [23:0]       mb;
      logic [47:0]       p;
      logic [5:0]        lz;
      logic signed [11:0] e;
      logic              za;
      logic              zb;
      word_type          w;
      s  = a[31] ^ b[31];
      za = (a[30:0] == 31'd0);
      zb = (b[30:0] == 31'd0);
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      p  = ma * mb;
      lz = lzc50({p, 2'b00});
      e  = 12'(a[30:23] == 8'd0 ? 8'd1 : a[30:23])
         + 12'(b[30:23] == 8'd0 ? 8'd1 : b[30:23]) - 12'sd126 - 12'(lz);
      if (is_nan(a)) begin
         w = a | QUIET_BIT;
      end else if (is_nan(b)) begin
         w = b | QUIET_BIT;
      end else if (a[30:23] == 8'hFF) begin
         w = zb ? DEFAULT_NAN : {s, 8'hFF, 23'd0};
      end else if (b[30:23] == 8'hFF) begin
         w = za ? DEFAULT_NAN : {s, 8'hFF, 23'd0};
      end else if (za || zb) begin
         w = {s, 31'd0};
      end else begin
         w = fp_round(s, e, {p, 2'b00} << lz);
      end
      return w;
   endfunction

   // a + b, or a - b when sub is set.
   function automatic word_type fp_add(input word_type a, input word_type b, input logic sub);
      logic        bs;
      logic [7:0]  ea;
      logic [7:0]  eb;
      logic [23:0] ma;
      logic [23:0] mb;
      logic        swap;
      logic [7:0]  eg;
      logic [7:0]  el;
      logic [23:0] mg;
      logic [23:0] ml;
      logic        sg;
      logic        sl;
      logic [49:0] y;
      logic [50:0] sum;
      logic [5:0]  lz;
      word_type    w;
      bs   = b[31] ^ sub;
      ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma   = {a[30:23] != 8'd0, a[22:0]};
      mb   = {b[30:23] != 8'd0, b[22:0]};
      swap = {ea, ma} < {eb, mb};
      eg   = swap ? eb : ea;
      el   = swap ? ea : eb;
      mg   = swap ? mb : ma;
      ml   = swap ? ma : mb;
      sg   = swap ? bs : a[31];
      sl   = swap ? a[31] : bs;
      y    = shr_sticky({ml, 26'd0}, eg - el);
      sum  = (sg == sl) ? ({1'b0, mg, 26'd0} + {1'b0, y})
                        : ({1'b0, mg, 26'd0} - {1'b0, y});
      lz   = lzc50(sum[49:0]);
      if (is_nan(a)) begin
         w = a | QUIET_BIT;
      end else if (is_nan(b)) begin
         w = b | QUIET_BIT;
      end else if (a[30:23] == 8'hFF && b[30:23] == 8'hFF) begin
         w = (a[31] != bs) ? DEFAULT_NAN : a;
      end else if (a[30:23] == 8'hFF) begin
         w = a;
      end else if (b[30:23] == 8'hFF) begin
         w = {bs, b[30:0]};
      end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
         w = {a[31] & bs, 31'd0};
      end else if (sum == 51'd0) begin
         w = 32'd0;
      end else if (sum[50]) begin
         w = fp_round(sg, 12'(eg) + 12'sd1, {sum[50:2], sum[1] | sum[0]});
      end else begin
         w = fp_round(sg, 12'(eg) - 12'(lz), sum[49:0] << lz);
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/exp_approx_float32_table.sv =====
// Top level of the table-based single-precision exp approximation.
// Depends on eaf32t_pkg and on exp_approx_float32_table_macros.svh.
//
//   Channel  Handshake               Payload
//   req      req_valid / req_stall   req_kind, req_value, req_table_index
//   rsp      rsp_valid / rsp_stall   rsp_result
//   csr      csr_valid / csr_ready   csr_index, csr_data
//
// One transaction enters per cycle unless req_stall is high; a compute transaction
// passes an eight-stage pipeline with one float operation per stage and the
// table memory read in the middle.
// A table-write transaction writes the memory in the same stage where compute
// transactions read it, so every read sees exactly the writes before it.
// Reset is synchronous, clears the stage valid bits and sets the configuration
// registers to their reset values; the table memory is not cleared. A stalled result stalls the whole pipe.
`default_nettype none

`include "exp_approx_float32_table_macros.svh"

module exp_approx_float32_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [31:0] req_value,
   input  wire logic [9:0]  req_table_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_result,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [eaf32t_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int TIB = eaf32t_pkg::TABLE_INDEX_BITS;

   // Configuration registers.
   eaf32t_pkg::word_type magic_ff, scale_a_ff, scale_b_ff, max_x_ff, min_x_ff;

   // The whole pipe moves together unless a finished result is held back.
   logic adv;

   // Stage registers.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, rsp_valid_ff;
   logic k1_ff, k2_ff, k3_ff;
   logic [TIB-1:0] idx1_ff, idx2_ff, idx3_ff;
   eaf32t_pkg::word_type val1_ff, val2_ff, val3_ff;
   eaf32t_pkg::word_type x1_ff, x2_ff, x3_ff, x4_ff, x5_ff;
   eaf32t_pkg::word_type prod2_ff, fi3_ff, fi4_ff, back4_ff, corr5_ff, e5_ff;
   eaf32t_pkg::word_type t6_ff, e6_ff, sc7_ff, e7_ff, rsp_result_ff;
   eaf32t_pkg::word_type rd_ff;

   eaf32t_pkg::word_type tbl_mem [eaf32t_pkg::TABLE_DEPTH];

   eaf32t_pkg::word_type clamp_hi, x_in, e5_in;
   logic [31:0] expo_sum;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign csr_ready = 1'b1;

   // Clamp with SSE operand order: a NaN input falls to max_x, then min_x.
   always_comb begin
      clamp_hi = eaf32t_pkg::fp_lt(req_value, max_x_ff) ? req_value : max_x_ff;
      x_in     = eaf32t_pkg::fp_lt(min_x_ff, clamp_hi) ? clamp_hi : min_x_ff;
   end

   // Exponent field from the bits of fi, combined with the table word.
   always_comb begin
      expo_sum = fi4_ff + eaf32t_pkg::EXP_ADJ;
      e5_in    = ((expo_sum >> TIB) << 23) | rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= eaf32t_pkg::MAGIC_BIAS_RESET;
         scale_a_ff <= '0;
         scale_b_ff <= '0;
         max_x_ff   <= '0;
         min_x_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            eaf32t_pkg::CSR_MAGIC_BIAS: magic_ff   <= csr_data;
            eaf32t_pkg::CSR_SCALE_A:    scale_a_ff <= csr_data;
            eaf32t_pkg::CSR_SCALE_B:    scale_b_ff <= csr_data;
            eaf32t_pkg::CSR_MAX_X:      max_x_ff   <= csr_data;
            eaf32t_pkg::CSR_MIN_X:      min_x_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         // Table writes leave the pipe once the memory has taken them.
         v4_ff        <= v3_ff && !k3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         rsp_valid_ff <= v7_ff;
      end
   end

   // Datapath: one float operation per stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         k1_ff   <= req_kind;
         idx1_ff <= req_table_index[TIB-1:0];
         val1_ff <= req_value;
         x1_ff   <= x_in;

         k2_ff    <= k1_ff;
         idx2_ff  <= idx1_ff;
         val2_ff  <= val1_ff;
         x2_ff    <= x1_ff;
         prod2_ff <= eaf32t_pkg::fp_mul(x1_ff, scale_a_ff);

         k3_ff   <= k2_ff;
         idx3_ff <= idx2_ff;
         val3_ff <= val2_ff;
         x3_ff   <= x2_ff;
         fi3_ff  <= eaf32t_pkg::fp_add(prod2_ff, magic_ff, 1'b0);

         x4_ff    <= x3_ff;
         fi4_ff   <= fi3_ff;
         back4_ff <= eaf32t_pkg::fp_add(fi3_ff, magic_ff, 1'b1);

         x5_ff    <= x4_ff;
         corr5_ff <= eaf32t_pkg::fp_mul(back4_ff, scale_b_ff);
         e5_ff    <= e5_in;

         t6_ff <= eaf32t_pkg::fp_add(x5_ff, corr5_ff, 1'b1);
         e6_ff <= e5_ff;

         sc7_ff <= eaf32t_pkg::fp_mul(t6_ff, e6_ff);
         e7_ff  <= e6_ff;

         rsp_result_ff <= eaf32t_pkg::fp_add(sc7_ff, e7_ff, 1'b0);
      end
   end

   // Table memory: at most one write and one read per advance, read data registered.
   always_ff @(posedge clock) begin
      if (adv) begin
         if (v3_ff && k3_ff) begin
            tbl_mem[idx3_ff] <= val3_ff;
         end
         rd_ff <= tbl_mem[fi3_ff[TIB-1:0]];
      end
   end

   // Only compute transactions pass the memory stage.
   `EAF_ASSERT_NEXT(a_write_drops, clock, reset, adv, v4_ff == $past(v3_ff && !k3_ff))
   // A held result and the pipe behind it keep their values while stalled.
   `EAF_ASSERT_NEXT(a_rd_holds, clock, reset, !adv, $stable(rsp_result) && $stable(v5_ff))
   // Input stall follows only from a held result.
   `EAF_ASSERT_NOW(a_stall_src, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

`default_nettype wire

// ===== dv/tb_exp_approx_float32_table.sv =====
// Self-checking testbench for the table-based single-precision exp block.
// Depends on eaf32t_pkg and on the exp_approx_float32_table top level.
`default_nettype none

module tb_exp_approx_float32_table;

   // Operation carried by one request transaction.
   typedef enum logic {OP_EXP = 1'b0, OP_LOAD = 1'b1} op_type;

   typedef struct {
      op_type      kind;
      logic [31:0] value;
      logic [9:0]  index;
   } req_item_type;

   // Register index beyond the last defined one; writes to it are dropped.
   localparam logic [eaf32t_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd5;
   localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
   localparam logic [31:0] F32_SNAN = 32'h7F80_0001;
   localparam logic [31:0] F32_INF  = 32'h7F80_0000;
   localparam logic [31:0] F32_NINF = 32'hFF80_0000;
   localparam logic [31:0] F32_MAX  = 32'h7F7F_FFFF;
   localparam logic [31:0] F32_TINY = 32'h0000_0001;
   localparam logic [31:0] F32_NZER = 32'h8000_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [31:0] req_value = '0;
   logic [9:0]  req_table_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [eaf32t_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   exp_approx_float32_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_value(req_value), .req_table_index(req_table_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result(rsp_result),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Predictor state: a private copy of the registers and the scale table.
   logic [31:0] bias_reg = eaf32t_pkg::MAGIC_BIAS_RESET;
   logic [31:0] a_reg = '0;
   logic [31:0] b_reg = '0;
   logic [31:0] hi_reg = '0;
   logic [31:0] lo_reg = '0;
   logic [31:0] scale_words [eaf32t_pkg::TABLE_DEPTH];

   // Entries already queued for loading; the stimulus never reads any other.
   bit          loaded [eaf32t_pkg::TABLE_DEPTH];

   req_item_type pending_reqs[$];
   logic [31:0]  expected_exps[$];
   req_item_type cur_req;
   int          error_count = 0;
   int          exp_count = 0;
   int          load_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_requests = 0;

   // ---------------------------------------------------------------------
   // Single-precision arithmetic. Each operation is carried out in double
   // precision, where a product or a sum of two singles is exact or rounds
   // innocuously, and is then rounded once to single, nearest-even.
   // ---------------------------------------------------------------------
   function automatic bit f32_is_nan(input logic [31:0] w);
      return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
   endfunction

   function automatic real f32_to_real(input logic [31:0] w);
      real r;
      if (w[30:23] == 8'd0) begin
         r = real'(w[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
         r = w[31] ? -r : r;
      end else if (w[30:23] == 8'hFF) begin
         r = $bitstoreal({w[31], 11'h7FF, w[22:0], 29'd0});
      end else begin
         r = $bitstoreal({w[31], 11'(w[30:23]) + 11'd896, w[22:0], 29'd0});
      end
      return r;
   endfunction

   function automatic logic [31:0] real_to_f32(input real r);
      logic [63:0]     d;
      longint unsigned sig;
      longint unsigned q;
      longint unsigned rem;
      longint unsigned half;
      longint unsigned mag;
      int              e;
      int              sh;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) begin
         return (d[51:0] != 52'd0) ? eaf32t_pkg::DEFAULT_NAN : {d[63], 8'hFF, 23'd0};
      end
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      e = int'(d[62:52]) - 1023;
      if (e + 127 >= 255) return {d[63], 8'hFF, 23'd0};
      sig = {12'd1, d[51:0]};
      sh = (e + 127 >= 1) ? 29 : -e - 97;
      if (sh > 60) return {d[63], 31'd0};
      q = sig >> sh;
      rem = sig - (q << sh);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      mag = (e + 127 >= 1) ? ((longint'(e + 126) << 23) + q) : q;
      return {d[63], mag[30:0]};
   endfunction

   function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
      if (f32_is_nan(a)) return a | eaf32t_pkg::QUIET_BIT;
      if (f32_is_nan(b)) return b | eaf32t_pkg::QUIET_BIT;
      return real_to_f32(f32_to_real(a) * f32_to_real(b));
   endfunction

   function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b,
                                           input bit negate_b);
      real rb;
      if (f32_is_nan(a)) return a | eaf32t_pkg::QUIET_BIT;
      if (f32_is_nan(b)) return b | eaf32t_pkg::QUIET_BIT;
      rb = f32_to_real(b);
      return real_to_f32(f32_to_real(a) + (negate_b ? -rb : rb));
   endfunction

   function automatic bit f32_less(input logic [31:0] a, input logic [31:0] b);
      if (f32_is_nan(a) || f32_is_nan(b)) return 1'b0;
      return f32_to_real(a) < f32_to_real(b);
   endfunction

   // Approximate exp of one input under the current registers. The bits of
   // the biased integer part are handed back so that the stimulus can make
   // sure the scale entry it selects has been loaded.
   function automatic logic [31:0] approx_exp(input logic [31:0] x_in,
                                              output logic [31:0] fi);
      logic [31:0] x;
      logic [31:0] back;
      logic [31:0] t;
      logic [31:0] e;
      // The clamp keeps the second operand whenever a compare fails, so a
      // NaN input falls to max_x and a NaN max_x falls through to min_x.
      x = f32_less(x_in, hi_reg) ? x_in : hi_reg;
      x = f32_less(lo_reg, x) ? x : lo_reg;
      fi = f32_add(f32_mul(x, a_reg), bias_reg, 1'b0);
      back = f32_add(fi, bias_reg, 1'b1);
      t = f32_add(x, f32_mul(back, b_reg), 1'b1);
      e = (((fi + eaf32t_pkg::EXP_ADJ) >> eaf32t_pkg::TABLE_INDEX_BITS) << 23)
        | scale_words[fi[eaf32t_pkg::TABLE_INDEX_BITS-1:0]];
      return f32_add(f32_mul(t, e), e, 1'b0);
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset and the run limit.
   // ---------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("  run limit reached: %0d requests queued, %0d results outstanding",
               pending_reqs.size(), expected_exps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver. A transaction is taken at an edge where valid is high
   // and stall is low; the predictor is updated at that same edge, so its
   // table always matches what the block has seen. The payload is only
   // replaced once the current transaction is gone.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic [31:0] fi;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (cur_req.kind == OP_LOAD) begin
               scale_words[cur_req.index] = cur_req.value;
               load_count++;
            end else begin
               expected_exps.push_back(approx_exp(cur_req.value, fi));
               exp_count++;
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && !hold_requests
                && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_kind <= cur_req.kind;
               req_value <= cur_req.value;
               req_table_index <= cur_req.index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Result monitor: every accepted result is checked against the oldest
   // prediction, and the stall is rolled for the next edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_exps.size() == 0) begin
               report_mismatch("result transaction with no prediction waiting",
                               rsp_result, 32'd0);
            end else begin
               logic [31:0] want;
               want = expected_exps.pop_front();
               if (rsp_result !== want) report_mismatch("result", rsp_result, want);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   task automatic queue_load(input logic [9:0] index, input logic [31:0] word);
      req_item_type it;
      it.kind = OP_LOAD;
      it.value = word;
      it.index = index;
      pending_reqs.push_back(it);
      loaded[index] = 1'b1;
   endtask

   // Most scale entries hold a mantissa only, as a real table would.
   function automatic logic [31:0] scale_word();
      return ($urandom_range(0, 9) == 0) ? $urandom() : {9'd0, 23'($urandom())};
   endfunction

   // Queues one exp transaction. If the scale entry it will select has never
   // been loaded, a load for that entry goes ahead of it. The registers do not
   // change while a phase is queued, so the selected entry is known here.
   task automatic queue_exp(input logic [31:0] x);
      req_item_type it;
      logic [31:0]  fi;
      void'(approx_exp(x, fi));
      if (!loaded[fi[9:0]]) queue_load(fi[9:0], scale_word());
      it.kind = OP_EXP;
      it.value = x;
      it.index = 10'($urandom());
      pending_reqs.push_back(it);
   endtask

   task automatic write_csr(input logic [eaf32t_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         eaf32t_pkg::CSR_MAGIC_BIAS: bias_reg = data;
         eaf32t_pkg::CSR_SCALE_A:    a_reg = data;
         eaf32t_pkg::CSR_SCALE_B:    b_reg = data;
         eaf32t_pkg::CSR_MAX_X:      hi_reg = data;
         eaf32t_pkg::CSR_MIN_X:      lo_reg = data;
         default: ;
      endcase
   endtask

   // Waits until every request is taken and every result is back, then lets
   // the eight-stage pipe run dry behind a trailing load.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_exps.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Random inputs: mostly ordinary arguments, with raw bit patterns and
   // special values mixed in, plus random loads of the scale table.
   task automatic queue_random(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            queue_load(10'($urandom()), scale_word());
         end else if (pick < 62) begin
            queue_exp(real_to_f32((real'($urandom_range(0, 200000)) - 100000.0) / 1000.0));
         end else if (pick < 90) begin
            queue_exp($urandom());
         end else begin
            case ($urandom_range(0, 5))
               0: queue_exp(F32_QNAN | 32'($urandom_range(0, 1)) << 31);
               1: queue_exp(F32_INF);
               2: queue_exp(F32_NINF);
               3: queue_exp({1'($urandom()), 8'd0, 23'($urandom())});
               4: queue_exp(F32_NZER);
               default: queue_exp(32'd0);
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin
      foreach (scale_words[i]) scale_words[i] = '0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Phase one: registers at their reset values, where every input clamps
      // to zero. Then the usual single-precision constants.
      send_idle_pct = 7;
      recv_idle_pct = 86;
      queue_exp(32'h3F80_0000);
      queue_exp(F32_QNAN);
      drain();
      write_csr(eaf32t_pkg::CSR_MAGIC_BIAS, eaf32t_pkg::MAGIC_BIAS_RESET);
      write_csr(eaf32t_pkg::CSR_SCALE_A, real_to_f32(1024.0 / 0.6931471805599453));
      write_csr(eaf32t_pkg::CSR_SCALE_B, real_to_f32(0.6931471805599453 / 1024.0));
      write_csr(eaf32t_pkg::CSR_MAX_X, real_to_f32(88.72));
      write_csr(eaf32t_pkg::CSR_MIN_X, real_to_f32(-87.33));

      // Directed: the ends of every field, the NaN inputs, inputs on and
      // past each clamp bound, and loads at the end entries of the table.
      queue_load(10'd0, 32'd0);
      queue_load(10'h3FF, 32'hFFFF_FFFF);
      queue_load(10'h3FF, {9'd0, 23'h7FFFFF});
      queue_exp(32'd0);
      queue_exp(F32_NZER);
      queue_exp(F32_QNAN);
      queue_exp(32'hFFFF_FFFF);
      queue_exp(F32_SNAN);
      queue_exp(F32_INF);
      queue_exp(F32_NINF);
      queue_exp(F32_MAX);
      queue_exp(F32_MAX | 32'h8000_0000);
      queue_exp(F32_TINY);
      queue_exp(32'h3F80_0000);
      queue_exp(32'hBF80_0000);
      queue_exp(real_to_f32(88.72));
      queue_exp(real_to_f32(-87.33));
      queue_exp(real_to_f32(89.0));
      queue_exp(real_to_f32(-100.0));
      queue_exp(real_to_f32(0.5));
      queue_random(150);
      drain();

      // Phase two: extreme registers. A NaN upper bound sends every input to
      // the lower bound; the largest finite scale, a NaN scale and a zero bias come next.
      send_idle_pct = 86;
      recv_idle_pct = 7;
      write_csr(eaf32t_pkg::CSR_MAX_X, 32'hFFFF_FFFF);
      write_csr(eaf32t_pkg::CSR_MIN_X, F32_NINF);
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      queue_random(40);
      drain();
      write_csr(eaf32t_pkg::CSR_MAGIC_BIAS, 32'd0);
      write_csr(eaf32t_pkg::CSR_SCALE_A, F32_MAX);
      write_csr(eaf32t_pkg::CSR_SCALE_B, 32'hFFFF_FFFF);
      write_csr(eaf32t_pkg::CSR_MAX_X, F32_INF);
      write_csr(eaf32t_pkg::CSR_MIN_X, 32'd0);
      queue_random(150);
      drain();
      write_csr(eaf32t_pkg::CSR_MAGIC_BIAS, 32'hFFFF_FFFF);
      write_csr(eaf32t_pkg::CSR_SCALE_A, 32'd0);
      write_csr(eaf32t_pkg::CSR_SCALE_B, 32'd0);
      write_csr(eaf32t_pkg::CSR_MAX_X, 32'd0);
      write_csr(eaf32t_pkg::CSR_MIN_X, 32'hFFFF_FFFF);
      queue_random(150);
      drain();

      // Phase three: random registers, no idling on either side. Partway
      // through, the sender holds off until every result has returned.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(eaf32t_pkg::CSR_MAGIC_BIAS, eaf32t_pkg::MAGIC_BIAS_RESET);
      write_csr(eaf32t_pkg::CSR_SCALE_A, $urandom());
      write_csr(eaf32t_pkg::CSR_SCALE_B, $urandom());
      write_csr(eaf32t_pkg::CSR_MAX_X, real_to_f32(real'($urandom_range(0, 100))));
      write_csr(eaf32t_pkg::CSR_MIN_X, $urandom());
      queue_random(180);
      while (pending_reqs.size() > 90) @(posedge clock);
      hold_requests = 1;
      while (req_valid || expected_exps.size() > 0) @(posedge clock);
      hold_requests = 0;
      drain();
      write_csr(eaf32t_pkg::CSR_MAGIC_BIAS, eaf32t_pkg::MAGIC_BIAS_RESET);
      write_csr(eaf32t_pkg::CSR_SCALE_A, real_to_f32(1024.0 / 0.6931471805599453));
      write_csr(eaf32t_pkg::CSR_SCALE_B, real_to_f32(0.6931471805599453 / 1024.0));
      write_csr(eaf32t_pkg::CSR_MAX_X, real_to_f32(88.72));
      write_csr(eaf32t_pkg::CSR_MIN_X, real_to_f32(-87.33));
      queue_random(130);
      drain();

      $display("Covered %0d exp transactions and %0d table loads over reset, nominal,",
               exp_count, load_count);
      $display("NaN-bound, extreme and random register settings; %0d mismatches.",
               error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/eaf32t_pkg.sv
rtl/exp_approx_float32_table.sv
dv/tb_exp_approx_float32_table.sv
